[rtl/gpmr_pkg.sv]
// Package for the six-pin GPIO mode resolver: operation codes, register kinds,
// port masks, the packed state type and its reset value.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gpmr_pkg;

    localparam int NUM_PINS  = 6;
    localparam int NUM_KINDS = 8;

    // Valid bits of each port's byte registers.
    localparam logic [7:0] PORT3_MASK = 8'h0f;
    localparam logic [7:0] PORT5_MASK = 8'h30;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DRIVE = 2'd2,
        FUNC_FLOAT = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_LATCH  = 3'd0,
        KIND_MODE1  = 3'd1,
        KIND_MODE0  = 3'd2,
        KIND_PULLUP = 3'd3,
        KIND_NCS    = 3'd4,
        KIND_SLEW   = 3'd5,
        KIND_DRIVE  = 3'd6,
        KIND_IE     = 3'd7
    } t_kind;

    typedef logic [NUM_PINS-1:0] t_pins;

    // One input item, as captured from the input channel.
    typedef struct packed {
        logic [1:0] func;
        logic [3:0] reg_index;
        logic [7:0] write_data;
        logic [2:0] pin_index;
        logic       pin_level_in;
        logic       read_latch;
    } t_item;

    // Register contents are kept per pin: kind k, pin n sits at kinds[k][n].
    typedef struct packed {
        logic [NUM_KINDS-1:0][NUM_PINS-1:0] kinds;
        t_pins                              ext_level;
        t_pins                              ext_driven;
    } t_state;

    localparam t_state RESET_STATE = '{
        kinds:      {6'h3f, 6'h3f, 6'h3f, 6'h00, 6'h00, 6'h00, 6'h3c, 6'h3f},
        ext_level:  6'h3f,
        ext_driven: 6'h3f
    };

    // Byte mask of the port selected by the top bit of a register index.
    function automatic logic [7:0] port_mask(input logic port);
        return port ? PORT5_MASK : PORT3_MASK;
    endfunction

endpackage

`default_nettype wire

[rtl/gpmr_if.sv]
// Valid/ready channel interfaces of the GPIO mode resolver: the item channel
// and the result channel. Depends on gpmr_pkg for the pin width.
`default_nettype none

interface gpmr_in_if import gpmr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] pin_index;
    logic       pin_level_in;
    logic       read_latch;

    modport source (output valid, func, reg_index, write_data, pin_index,
                    pin_level_in, read_latch, input ready);
    modport sink   (input valid, func, reg_index, write_data, pin_index,
                    pin_level_in, read_latch, output ready);
endinterface

interface gpmr_out_if import gpmr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [7:0]          read_data;
    logic [NUM_PINS-1:0] pin_levels;
    logic [1:0]          int_lines;
    logic [1:0]          counter_lines;

    modport source (output valid, read_data, pin_levels, int_lines, counter_lines,
                    input ready);
    modport sink   (input valid, read_data, pin_levels, int_lines, counter_lines,
                    output ready);
endinterface

`default_nettype wire

[rtl/gpmr_regs.sv]
// Port register file and external pin state of the GPIO mode resolver.
// Holds the state and works out its next value for an item. Uses gpmr_pkg.
`default_nettype none

module gpmr_regs import gpmr_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_accept,
    input  wire t_item  i_item,
    output t_state      o_state,
    output t_state      o_state_next
);

    localparam t_pins PIN_ONE = {{(NUM_PINS-1){1'b0}}, 1'b1};

    t_state     r_state;
    t_state     n_state;
    t_pins      pin_bit;
    t_pins      wr_mask;
    logic [7:0] port_bits;
    logic [2:0] kind;

    assign kind      = i_item.reg_index[2:0];
    assign port_bits = port_mask(i_item.reg_index[3]);
    assign wr_mask   = port_bits[NUM_PINS-1:0];
    assign pin_bit   = PIN_ONE << i_item.pin_index;

    // Next state: a write replaces the port's valid bits, drive and float
    // touch one pin of the external state, a read leaves everything alone.
    always_comb begin
        n_state = r_state;
        case (i_item.func)
            FUNC_WRITE: begin
                n_state.kinds[kind] = (r_state.kinds[kind] & ~wr_mask)
                                    | (i_item.write_data[NUM_PINS-1:0] & wr_mask);
            end
            FUNC_DRIVE: begin
                if (i_item.pin_index < 3'(NUM_PINS)) begin
                    n_state.ext_level  = i_item.pin_level_in
                                       ? (r_state.ext_level | pin_bit)
                                       : (r_state.ext_level & ~pin_bit);
                    n_state.ext_driven = r_state.ext_driven | pin_bit;
                end
            end
            FUNC_FLOAT: begin
                if (i_item.pin_index < 3'(NUM_PINS)) begin
                    n_state.ext_driven = i_item.pin_level_in
                                       ? (r_state.ext_driven & ~pin_bit)
                                       : (r_state.ext_driven | pin_bit);
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // State register, updated on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RESET_STATE;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_state      = r_state;
    assign o_state_next = n_state;

endmodule

`default_nettype wire

[rtl/gpmr_resolve.sv]
// Pin level resolver: turns mode, latch, pull-up and external state into the
// level of every pin. Purely combinational. Uses gpmr_pkg.
`default_nettype none

module gpmr_resolve import gpmr_pkg::*; (
    input  wire t_state i_state,
    output t_pins       o_levels
);

    t_pins outside;

    // Each pin on its own: the mode pair selects the rule.
    always_comb begin
        for (int n = 0; n < NUM_PINS; n++) begin
            outside[n] = i_state.ext_driven[n] ? i_state.ext_level[n]
                                               : i_state.kinds[KIND_PULLUP][n];
            case ({i_state.kinds[KIND_MODE1][n], i_state.kinds[KIND_MODE0][n]})
                2'b01:   o_levels[n] = i_state.kinds[KIND_LATCH][n];
                2'b10:   o_levels[n] = outside[n];
                2'b11:   o_levels[n] = i_state.kinds[KIND_LATCH][n] & outside[n];
                // Quasi-bidirectional: weak pull-up unless driven from outside.
                default: o_levels[n] = i_state.kinds[KIND_LATCH][n]
                                     & (!i_state.ext_driven[n] | i_state.ext_level[n]);
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/gpmr_top.sv]
// Six-pin GPIO mode resolver, top level. Port 3 owns pins 0 to 3 and port 5
// pins 4 and 5; each port has eight byte registers addressed by reg_index.
// Every item (register read, register write, external drive, pin float)
// yields one result in the cycle after its transfer, carrying the read byte and
// the resolved pin, interrupt and counter levels after the operation. One item
// is taken every cycle; the only storage in the path is the state register
// and the result register, and an item is refused only while a result waits
// to be taken. Reset restores the documented register values, with all pins
// driven high from outside.
// Depends on gpmr_pkg, gpmr_if, gpmr_regs and gpmr_resolve.
`default_nettype none

module gpio_pin_mode_resolver_top import gpmr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gpmr_in_if.sink    i_in,
    gpmr_out_if.source o_out
);

    t_item      item;
    t_state     cur_state;
    t_state     nxt_state;
    t_pins      cur_levels;
    t_pins      nxt_levels;
    logic       accept;
    logic [7:0] mask;
    logic [7:0] data_val;

    logic       r_valid;
    logic [7:0] r_read_data;
    t_pins      r_pin_levels;
    logic [1:0] r_int_lines;
    logic [1:0] r_counter_lines;
    logic [7:0] n_read_data;

    assign item = '{
        func:         i_in.func,
        reg_index:    i_in.reg_index,
        write_data:   i_in.write_data,
        pin_index:    i_in.pin_index,
        pin_level_in: i_in.pin_level_in,
        read_latch:   i_in.read_latch
    };

    // A new item is taken whenever the result register is free or draining.
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    gpmr_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (item),
        .o_state      (cur_state),
        .o_state_next (nxt_state)
    );

    // Levels before the operation feed data reads, levels after feed the result.
    gpmr_resolve u_resolve_cur (
        .i_state  (cur_state),
        .o_levels (cur_levels)
    );

    gpmr_resolve u_resolve_nxt (
        .i_state  (nxt_state),
        .o_levels (nxt_levels)
    );

    // Read data: data registers fill invalid bits with ones, others with zeros.
    assign mask = port_mask(item.reg_index[3]);

    always_comb begin
        data_val = {{(8-NUM_PINS){1'b0}},
                    item.read_latch ? cur_state.kinds[KIND_LATCH]
                                    : (cur_state.kinds[KIND_IE] & cur_levels)};
        n_read_data = 8'h00;
        if (item.func == FUNC_READ) begin
            if (item.reg_index[2:0] == KIND_LATCH) begin
                n_read_data = (data_val & mask) | ~mask;
            end else begin
                n_read_data = {{(8-NUM_PINS){1'b0}},
                               cur_state.kinds[item.reg_index[2:0]]} & mask;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload, loaded on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data     <= n_read_data;
            r_pin_levels    <= nxt_levels;
            r_int_lines     <= nxt_levels[3:2] & nxt_state.kinds[KIND_IE][3:2];
            r_counter_lines <= nxt_levels[5:4] & nxt_state.kinds[KIND_IE][5:4];
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.read_data     = r_read_data;
    assign o_out.pin_levels    = r_pin_levels;
    assign o_out.int_lines     = r_int_lines;
    assign o_out.counter_lines = r_counter_lines;

`ifndef NO_ASSERTIONS
    // After reset no result is pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    // Every accepted item leaves a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted item produced no result");

    // A stalled result blocks the input side.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("item taken while result stalled");

    // Interrupt and counter lines are never high on a low pin.
    a_lines_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.int_lines & ~o_out.pin_levels[3:2]) == 2'b00
                      && (o_out.counter_lines & ~o_out.pin_levels[5:4]) == 2'b00))
        else $error("gated line high on a low pin");
`endif

endmodule

`default_nettype wire
